FILE: design/tun_pkg.sv
// Shared types and constants for the triangle unit normal core.
package tun_pkg;

    localparam int COORD_FIELD_W = 32;
    localparam int NORMAL_W      = 16;
    localparam int LANES         = 3;

    typedef struct packed {
        logic signed [COORD_FIELD_W-1:0] a_x;
        logic signed [COORD_FIELD_W-1:0] a_y;
        logic signed [COORD_FIELD_W-1:0] a_z;
        logic signed [COORD_FIELD_W-1:0] b_x;
        logic signed [COORD_FIELD_W-1:0] b_y;
        logic signed [COORD_FIELD_W-1:0] b_z;
        logic signed [COORD_FIELD_W-1:0] c_x;
        logic signed [COORD_FIELD_W-1:0] c_y;
        logic signed [COORD_FIELD_W-1:0] c_z;
    } t_tri;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic                       degenerate;
    } t_normal;

    // travels alongside the datapath through the front end and the cells
    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [LANES-1:0] neg;
    } t_ctrl;

endpackage

FILE: design/tun_front.sv
// Front end: edges, cross product, squared components and their sum.
module tun_front #(
    parameter int CW   = 32,
    parameter int F    = 14,
    parameter int MW   = 2 * CW + 2,
    parameter int SUMW = 2 * MW + 2,
    parameter int WW   = SUMW + 2 * F + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  tun_pkg::t_tri                i_tri,
    output tun_pkg::t_ctrl               o_ctrl,
    output logic [SUMW-1:0]              o_sum,
    output logic [tun_pkg::LANES-1:0][WW-1:0] o_rem
);
    import tun_pkg::*;

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int HW = MW / 2;
    localparam int SW = 2 * MW;

    logic [4:0] r_vld;

    logic signed [EW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [PW-1:0] r_p [2*LANES];
    logic [MW-1:0]        r_mag [LANES];
    logic [LANES-1:0]     r_neg3, r_neg4, r_neg5;
    logic [2*HW-1:0]      r_hh [LANES];
    logic [2*HW-1:0]      r_hl [LANES];
    logic [2*HW-1:0]      r_ll [LANES];
    logic [SW-1:0]        r_sq [LANES];

    logic signed [PW:0]   w_d [LANES];
    logic signed [PW:0]   w_dm [LANES];
    logic [HW-1:0]        w_h [LANES];
    logic [HW-1:0]        w_l [LANES];

    function automatic logic signed [EW-1:0] sx(input logic [COORD_FIELD_W-1:0] x);
        logic signed [CW-1:0] t;
        t  = x[CW-1:0];
        sx = EW'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_ctrl <= '0;
        end else begin
            r_vld        <= {r_vld[3:0], i_start};
            o_ctrl.valid <= r_vld[4];
            o_ctrl.neg   <= r_neg5;
            o_ctrl.degen <= (r_sq[0] == '0) && (r_sq[1] == '0) && (r_sq[2] == '0);
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_d[k]  = (PW+1)'(r_p[2*k]) - (PW+1)'(r_p[2*k+1]);
            w_dm[k] = w_d[k][PW] ? -w_d[k] : w_d[k];
            w_h[k]  = r_mag[k][MW-1:HW];
            w_l[k]  = r_mag[k][HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux <= sx(i_tri.b_x) - sx(i_tri.a_x);
        r_uy <= sx(i_tri.b_y) - sx(i_tri.a_y);
        r_uz <= sx(i_tri.b_z) - sx(i_tri.a_z);
        r_vx <= sx(i_tri.c_x) - sx(i_tri.a_x);
        r_vy <= sx(i_tri.c_y) - sx(i_tri.a_y);
        r_vz <= sx(i_tri.c_z) - sx(i_tri.a_z);

        r_p[0] <= PW'(r_uy) * PW'(r_vz);
        r_p[1] <= PW'(r_vy) * PW'(r_uz);
        r_p[2] <= PW'(r_uz) * PW'(r_vx);
        r_p[3] <= PW'(r_vz) * PW'(r_ux);
        r_p[4] <= PW'(r_ux) * PW'(r_vy);
        r_p[5] <= PW'(r_vx) * PW'(r_uy);

        r_neg4 <= r_neg3;
        r_neg5 <= r_neg4;
        for (int k = 0; k < LANES; k++) begin
            r_mag[k]  <= w_dm[k][MW-1:0];
            r_neg3[k] <= w_d[k][PW];
            // square split into halves: m^2 = hh<<MW + 2hl<<HW + ll
            r_hh[k] <= (2*HW)'(w_h[k]) * (2*HW)'(w_h[k]);
            r_hl[k] <= (2*HW)'(w_h[k]) * (2*HW)'(w_l[k]);
            r_ll[k] <= (2*HW)'(w_l[k]) * (2*HW)'(w_l[k]);
            r_sq[k] <= (SW'(r_hh[k]) << MW) + (SW'(r_hl[k]) << (HW + 1)) + SW'(r_ll[k]);
            o_rem[k] <= WW'(r_sq[k]) << (2 * F);
        end
        o_sum <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
    end

endmodule

FILE: design/tun_cell.sv
// One cell of the root chain: decides one quotient bit for all three components.
module tun_cell #(
    parameter int SUMW = 134,
    parameter int WW   = 164,
    parameter int QW   = 15,
    parameter int BIT  = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tun_pkg::t_ctrl                    i_ctrl,
    input  logic [SUMW-1:0]                   i_sum,
    input  logic [tun_pkg::LANES-1:0][WW-1:0] i_rem,
    input  logic [tun_pkg::LANES-1:0][WW-1:0] i_acc,
    input  logic [tun_pkg::LANES-1:0][QW-1:0] i_q,
    output tun_pkg::t_ctrl                    o_ctrl,
    output logic [SUMW-1:0]                   o_sum,
    output logic [tun_pkg::LANES-1:0][WW-1:0] o_rem,
    output logic [tun_pkg::LANES-1:0][WW-1:0] o_acc,
    output logic [tun_pkg::LANES-1:0][QW-1:0] o_q
);
    import tun_pkg::*;

    // rem = m^2*2^2F - q^2*S, acc = q*S; (q+2^b)^2*S - q^2*S = acc<<(b+1) + S<<2b
    logic [WW-1:0] w_sum;
    logic [WW-1:0] w_d [LANES];
    logic          w_take [LANES];

    assign w_sum = WW'(i_sum);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_d[k]    = (i_acc[k] << (BIT + 1)) + (w_sum << (2 * BIT));
            w_take[k] = w_d[k] <= i_rem[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_sum <= i_sum;
        for (int k = 0; k < LANES; k++) begin
            if (w_take[k]) begin
                o_rem[k] <= i_rem[k] - w_d[k];
                o_acc[k] <= i_acc[k] + (w_sum << BIT);
                o_q[k]   <= i_q[k] | (QW'(1) << BIT);
            end else begin
                o_rem[k] <= i_rem[k];
                o_acc[k] <= i_acc[k];
                o_q[k]   <= i_q[k];
            end
        end
    end

endmodule

FILE: design/triangle_unit_normal_core.sv
// Top level of the triangle unit normal core: front end, root cell chain, result register.
// Takes one triangle per clock (busy stays low) and returns its unit face normal
// on o_result, marked by a one-cycle o_strobe. The path runs through six front-end
// stages (edges, cross products, magnitudes, split squares, squares, sum), one
// cell per quotient bit (NORMAL_FRAC_BITS + 1) and the result register. Results come
// in start order and cannot be held off; the receiver must take each strobe.
module triangle_unit_normal_core #(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tun_pkg::t_tri    i_tri,
    output logic             o_strobe,
    output tun_pkg::t_normal o_result
);
    import tun_pkg::*;

    localparam int F    = NORMAL_FRAC_BITS;
    localparam int MW   = 2 * COORD_WIDTH + 2;
    localparam int SUMW = 2 * MW + 2;
    localparam int WW   = SUMW + 2 * F + 2;
    localparam int QW   = F + 1;
    localparam int NC   = F + 1;
    localparam int LAT  = F + 8;

    t_ctrl                   w_ctrl [NC+1];
    logic [SUMW-1:0]         w_sum  [NC+1];
    logic [LANES-1:0][WW-1:0] w_rem [NC+1];
    logic [LANES-1:0][WW-1:0] w_acc [NC+1];
    logic [LANES-1:0][QW-1:0] w_q   [NC+1];

    t_normal          n_result;
    logic signed [QW:0] w_sv [LANES];

    assign busy = 1'b0;

    tun_front #(
        .CW   (COORD_WIDTH),
        .F    (F),
        .MW   (MW),
        .SUMW (SUMW),
        .WW   (WW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_tri   (i_tri),
        .o_ctrl  (w_ctrl[0]),
        .o_sum   (w_sum[0]),
        .o_rem   (w_rem[0])
    );

    assign w_acc[0] = '0;
    assign w_q[0]   = '0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        tun_cell #(
            .SUMW (SUMW),
            .WW   (WW),
            .QW   (QW),
            .BIT  (F - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_sum   (w_sum[g]),
            .i_rem   (w_rem[g]),
            .i_acc   (w_acc[g]),
            .i_q     (w_q[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_sum   (w_sum[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_sv[k] = $signed({1'b0, w_q[NC][k]});
            if (w_ctrl[NC].neg[k]) begin
                w_sv[k] = -w_sv[k];
            end
        end
        n_result.normal_x   = NORMAL_W'(w_sv[0]);
        n_result.normal_y   = NORMAL_W'(w_sv[1]);
        n_result.normal_z   = NORMAL_W'(w_sv[2]);
        n_result.degenerate = w_ctrl[NC].degen;
        // zero-length cross product: the chain saturates q, so force zeros
        if (w_ctrl[NC].degen) begin
            n_result.normal_x = '0;
            n_result.normal_y = '0;
            n_result.normal_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_ctrl[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_strobe)
        else $error("transaction result missing at expected latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without a matching transaction");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.degenerate |->
            o_result.normal_x == '0 && o_result.normal_y == '0 && o_result.normal_z == '0)
        else $error("degenerate result carries a nonzero normal");
`endif

endmodule

FILE: test/tun_checker.sv
// Scoreboard for the triangle unit normal core: predicts each normal and compares results.
module tun_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  tun_pkg::t_tri    i_tri,
    input  logic             i_strobe,
    input  tun_pkg::t_normal i_result,
    output int               o_errors,
    output int               o_pending
);
    import tun_pkg::*;

    t_normal normal_q[$];

    // exact cross product, length by bitwise square root search, truncation toward zero
    function automatic t_normal calc_normal(t_tri t);
        logic signed [33:0] ux, uy, uz, vx, vy, vz;
        logic signed [69:0] n[3];
        logic [69:0]        n_abs;
        logic [255:0]       m[3];
        logic [255:0]       sum, target, cand, q;
        logic [31:0]        comp;
        logic               neg[3];
        t_normal            r;
        int                 i, b;
        ux = t.b_x - t.a_x;
        uy = t.b_y - t.a_y;
        uz = t.b_z - t.a_z;
        vx = t.c_x - t.a_x;
        vy = t.c_y - t.a_y;
        vz = t.c_z - t.a_z;
        n[0] = uy * vz - vy * uz;
        n[1] = uz * vx - vz * ux;
        n[2] = ux * vy - vx * uy;
        sum = '0;
        for (i = 0; i < 3; i++) begin
            neg[i] = n[i] < 0;
            n_abs = neg[i] ? -n[i] : n[i];
            m[i] = 256'(n_abs);
            sum = sum + m[i] * m[i];
        end
        r = '0;
        if (sum == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        for (i = 0; i < 3; i++) begin
            target = (m[i] * m[i]) << (2 * FRAC_BITS);
            q = '0;
            for (b = FRAC_BITS; b >= 0; b--) begin
                cand = q | (256'd1 << b);
                if (cand * cand * sum <= target)
                    q = cand;
            end
            comp = neg[i] ? -q[31:0] : q[31:0];
            if (i == 0) r.normal_x = comp[15:0];
            else if (i == 1) r.normal_y = comp[15:0];
            else r.normal_z = comp[15:0];
        end
        return r;
    endfunction

    assign o_pending = normal_q.size();

    always @(posedge i_clk) begin
        t_normal want;
        if (!i_rst_n)
            o_errors <= 0;
        if (i_rst_n && i_start && !i_busy)
            normal_q.push_back(calc_normal(i_tri));
        if (i_rst_n && i_strobe) begin
            if (normal_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, i_result);
                o_errors <= o_errors + 1;
            end else begin
                want = normal_q.pop_front();
                if (want.normal_x !== i_result.normal_x ||
                    want.normal_y !== i_result.normal_y ||
                    want.normal_z !== i_result.normal_z ||
                    want.degenerate !== i_result.degenerate) begin
                    $display("%0t mismatch exp x=%0d y=%0d z=%0d dg=%0b act x=%0d y=%0d z=%0d dg=%0b",
                             $time, want.normal_x, want.normal_y, want.normal_z,
                             want.degenerate, i_result.normal_x, i_result.normal_y,
                             i_result.normal_z, i_result.degenerate);
                    o_errors <= o_errors + 1;
                end
            end
        end
    end
endmodule

FILE: test/tb_triangle_unit_normal_core.sv
// Stimulus and verdict for the triangle unit normal core.
module tb_triangle_unit_normal_core;
    import tun_pkg::*;

    localparam int FRAC     = 14;
    localparam int LATENCY  = FRAC + 8;
    localparam int MAX_CYC  = 400000;
    localparam int N_RANDOM = 530;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_tri    i_tri = '0;
    logic    o_strobe;
    t_normal o_result;
    int      errors, pending;
    int      cycles = 0;

    triangle_unit_normal_core #(.NORMAL_FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_tri(i_tri), .o_strobe(o_strobe), .o_result(o_result)
    );

    tun_checker #(.FRAC_BITS(FRAC)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_tri(i_tri), .i_strobe(o_strobe), .i_result(o_result),
        .o_errors(errors), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("status: fail");
            $finish;
        end
    end

    // one transaction: hold start until a cycle with busy low
    task automatic send_tri(t_tri t);
        start <= 1'b1;
        i_tri <= t;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0) return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom())};
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 32'h00200000)) - 32'h00100000;
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        logic signed [31:0] k;
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
        // collinear triangle, small edges from corner a
        if ($urandom_range(0, 7) == 0) begin
            k = $signed($urandom_range(0, 6)) - 3;
            t.b_x = t.a_x + ($signed($urandom_range(0, 200)) - 100);
            t.b_y = t.a_y + ($signed($urandom_range(0, 200)) - 100);
            t.b_z = t.a_z + ($signed($urandom_range(0, 200)) - 100);
            t.c_x = t.a_x + k * (t.b_x - t.a_x);
            t.c_y = t.a_y + k * (t.b_y - t.a_y);
            t.c_z = t.a_z + k * (t.b_z - t.a_z);
        end
        return t;
    endfunction

    function automatic t_tri mk(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        t_tri t;
        t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    localparam logic [31:0] ONE = 32'h00010000;
    localparam logic [31:0] MAXC = 32'h7fffffff;
    localparam logic [31:0] MINC = 32'h80000000;

    initial begin
        t_tri dir[$];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all corners coincident
        dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        // collinear corners
        dir.push_back(mk(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        // axis normals, both orientations
        dir.push_back(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        dir.push_back(mk(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
        dir.push_back(mk(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
        dir.push_back(mk(0, 0, 0, 0, 0, ONE, 0, ONE, 0));
        dir.push_back(mk(0, 0, 0, 0, 0, ONE, ONE, 0, 0));
        dir.push_back(mk(0, 0, 0, ONE, 0, 0, 0, 0, ONE));
        // diagonal and tiny edges
        dir.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        dir.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
        // extreme coordinates, widest edges
        dir.push_back(mk(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC));
        dir.push_back(mk(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC));
        dir.push_back(mk(MINC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC));
        dir.push_back(mk(MAXC, MINC, 0, MINC, MAXC, MINC, 0, MINC, MAXC));
        dir.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff,
                         0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 32'hffffffff));
        dir.push_back(mk(MINC, 0, 0, MAXC, 0, 0, MINC, 0, 0));
        foreach (dir[i]) send_tri(dir[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            idle_gap();
            send_tri(rand_tri());
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
design/tun_pkg.sv
design/tun_front.sv
design/tun_cell.sv
design/triangle_unit_normal_core.sv
test/tun_checker.sv
test/tb_triangle_unit_normal_core.sv
